@@ rtl/fsmf_pkg.sv @@
package fsmf_pkg;

    localparam int OFFSET_W     = 16;
    localparam int CHAR_FIELD_W = 16;
    localparam int POS_FIELD_W  = 16;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [CHAR_FIELD_W-1:0] char_value;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic                   found;
        logic [POS_FIELD_W-1:0] match_position;
    } t_out_item;

    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
    } t_win_ctrl;

endpackage

@@ rtl/fsmf_window.sv @@
module fsmf_window #(
    parameter int MAX_PATTERN = 16,
    parameter int CHAR_W      = 16,
    parameter int LEN_W       = 5
) (
    input  logic                 i_clk,
    input  fsmf_pkg::t_win_ctrl  i_ctrl,
    input  logic [CHAR_W-1:0]    i_char,
    input  logic [LEN_W-1:0]     i_len,
    output logic                 o_match
);
    import fsmf_pkg::*;

    // pattern held newest first, so entry i lines up with window entry i
    logic [CHAR_W-1:0] r_pat [MAX_PATTERN];
    logic [CHAR_W-1:0] r_txt [MAX_PATTERN];
    logic [CHAR_W-1:0] n_txt [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ok;

    always_comb begin
        n_txt[0] = i_char;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_txt[i] = r_txt[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            ok[i] = (LEN_W'(i) >= i_len) || (n_txt[i] == r_pat[i]);
        end
    end

    assign o_match = &ok;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pat_shift) begin
            r_pat[0] <= i_char;
            for (int i = 1; i < MAX_PATTERN; i++) begin
                r_pat[i] <= r_pat[i-1];
            end
        end
        if (i_ctrl.txt_shift) begin
            r_txt <= n_txt;
        end
    end

endmodule

@@ rtl/first_substring_match_finder_top.sv @@
// First substring match finder.
// Input channel (i_in_valid / o_in_stall, i_in_item): func selects a pattern
// character load or a text character; last ends the pattern or the text.
// A new pattern load replaces the stored pattern and abandons any text.
// Output channel (o_out_valid / i_out_stall, o_out_item): one item per text,
// either at the first match (found, match_position) or at the text's last
// character with found cleared.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets the
// start offset; ready is always high, write only while idle.
// Throughput: one item per cycle unless a stalled result holds the flow; the
// whole window is compared in parallel in the single stage between the input
// register and the result register, which takes the result of the item in the
// input register when the output is free.
// Reset clears pattern length, text position and both valid flags; the
// stored pattern itself is undefined until loaded.
// When the receiver stalls a held result, the result register keeps it and o_in_stall
// rises as soon as the input register also holds an item.
module first_substring_match_finder_top #(
    parameter int MAX_PATTERN = 16,
    parameter int CHAR_BITS   = 16,
    parameter int POS_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [fsmf_pkg::OFFSET_W-1:0]   i_cfg_data,
    output logic                            o_cfg_ready,
    input  logic                            i_in_valid,
    input  fsmf_pkg::t_in_item              i_in_item,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output fsmf_pkg::t_out_item             o_out_item,
    input  logic                            i_out_stall
);
    import fsmf_pkg::*;

    localparam int CHAR_W = (CHAR_BITS < CHAR_FIELD_W) ? CHAR_BITS : CHAR_FIELD_W;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam longint unsigned CAP = (64'd1 << POS_BITS) + 64'(MAX_PATTERN);
    localparam int IDX_W  = $clog2(CAP + 64'd1);
    localparam int CW     = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 1;
    localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(CAP);
    localparam logic [CW-1:0]    POS_MAX = CW'((64'd1 << POS_BITS) - 64'd1);

    logic [OFFSET_W-1:0] r_start_offset;
    logic                r_in_valid;
    t_in_item            r_in_item;
    logic [LEN_W-1:0]    r_len,     n_len;
    logic                r_loading, n_loading;
    logic [IDX_W-1:0]    r_idx,     n_idx;
    logic                r_done,    n_done;
    logic                r_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic             advance;
    logic             emit;
    logic             hit;
    logic             win_match;
    logic [LEN_W-1:0] len_base;
    logic [CW-1:0]    p1;
    logic [CW-1:0]    start;
    t_win_ctrl        win_ctrl;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign p1          = CW'(r_idx) + CW'(1);

    fsmf_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .CHAR_W      (CHAR_W),
        .LEN_W       (LEN_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_ctrl  (win_ctrl),
        .i_char  (r_in_item.char_value[CHAR_W-1:0]),
        .i_len   (r_len),
        .o_match (win_match)
    );

    always_comb begin
        n_len      = r_len;
        n_loading  = r_loading;
        n_idx      = r_idx;
        n_done     = r_done;
        emit       = 1'b0;
        hit        = 1'b0;
        start      = '0;
        len_base   = r_len;
        win_ctrl   = '0;
        n_out_item = '0;
        if (advance) begin
            if (r_in_item.func == FUNC_LOAD) begin
                len_base = r_loading ? r_len : '0;
                if (!r_loading) begin
                    n_idx  = '0;
                    n_done = 1'b0;
                end
                n_loading = !r_in_item.last;
                if (len_base < LEN_W'(MAX_PATTERN)) begin
                    win_ctrl.pat_shift = 1'b1;
                    n_len = len_base + LEN_W'(1);
                end else begin
                    n_len = len_base;
                end
            end else begin
                n_loading = 1'b0;
                if (r_done) begin
                    if (r_in_item.last) begin
                        n_idx  = '0;
                        n_done = 1'b0;
                    end
                end else begin
                    win_ctrl.txt_shift = 1'b1;
                    if (r_idx < IDX_CAP) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                    if (r_len == '0) begin
                        start = CW'(r_start_offset);
                        hit   = p1 >= CW'(r_start_offset);
                    end else if (p1 >= CW'(r_len)) begin
                        start = p1 - CW'(r_len);
                        hit   = (start >= CW'(r_start_offset)) && win_match;
                    end
                    if (start > POS_MAX) begin
                        hit = 1'b0;
                    end
                    if (hit) begin
                        emit                      = 1'b1;
                        n_out_item.found          = 1'b1;
                        n_out_item.match_position = start[POS_FIELD_W-1:0];
                        if (r_in_item.last) begin
                            n_idx = '0;
                        end else begin
                            n_done = 1'b1;
                        end
                    end else if (r_in_item.last) begin
                        emit  = 1'b1;
                        n_idx = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
            r_in_valid     <= 1'b0;
            r_len          <= '0;
            r_loading      <= 1'b0;
            r_idx          <= '0;
            r_done         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start_offset <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_len     <= n_len;
            r_loading <= n_loading;
            r_idx     <= n_idx;
            r_done    <= n_done;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (emit) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsmf_pkg::*;

    localparam int PAT_MAX     = 16;
    localparam int POS_LIMIT   = (1 << POS_FIELD_W) - 1;
    localparam int IDX_CAP     = POS_LIMIT + PAT_MAX + 1;
    localparam int IDLE_PAUSE  = 8;
    localparam int QUIET_LIMIT = 1000;
    localparam int ITEM_TARGET = 1750;

    typedef enum {ROW_ITEM, ROW_OFFSET} t_row_kind;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_RESULT} t_check;

    typedef struct {
        t_row_kind               kind;
        logic                    func;
        logic [CHAR_FIELD_W-1:0] ch;
        logic                    last;
        t_check                  chk;
        logic                    found;
        logic [POS_FIELD_W-1:0]  pos;
    } t_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [OFFSET_W-1:0] i_cfg_data  = '0;
    logic                o_cfg_ready;
    logic                i_in_valid  = 1'b0;
    t_in_item            i_in_item   = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_item           o_out_item;
    logic                i_out_stall = 1'b0;

    first_substring_match_finder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow state of the finder
    logic [CHAR_FIELD_W-1:0] pat_chars [PAT_MAX];
    logic [CHAR_FIELD_W-1:0] txt_win [PAT_MAX];
    int unsigned             pat_len    = 0;
    int unsigned             txt_pos    = 0;
    bit                      hit_seen   = 1'b0;
    bit                      load_open  = 1'b0;
    logic [OFFSET_W-1:0]     cur_offset = '0;

    t_out_item result_q [$];
    bit        idle_on   = 1'b0;
    int        n_items   = 0;
    int        n_results = 0;
    int        n_cfg     = 0;
    int        n_err     = 0;
    int        stall_cnt = 0;
    int        quiet     = 0;

    t_row dir_rows [25] = '{
        '{ROW_OFFSET, 1'b0,      16'd2,      1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0000,   1'b1, CHK_RESULT, 1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'hFFFF,   1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0001,   1'b0, CHK_RESULT, 1'b1, 16'd2},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0002,   1'b1, CHK_NONE,   1'b0, 16'd0},
        '{ROW_OFFSET, 1'b0,      16'd0,      1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h8000,   1'b0, CHK_RESULT, 1'b1, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h7FFF,   1'b1, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_LOAD, 16'hFFFF,   1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_LOAD, 16'h0000,   1'b1, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h1234,   1'b0, CHK_MODEL,  1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'hFFFF,   1'b0, CHK_MODEL,  1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0000,   1'b0, CHK_MODEL,  1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'hAAAA,   1'b1, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h5555,   1'b1, CHK_RESULT, 1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_LOAD, 16'h00FF,   1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h00FF,   1'b1, CHK_MODEL,  1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0001,   1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_LOAD, 16'h0001,   1'b1, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0001,   1'b1, CHK_MODEL,  1'b0, 16'd0},
        '{ROW_OFFSET, 1'b0,      16'hFFFF,   1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0001,   1'b1, CHK_RESULT, 1'b0, 16'd0},
        '{ROW_OFFSET, 1'b0,      16'd1,      1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0001,   1'b0, CHK_NONE,   1'b0, 16'd0},
        '{ROW_ITEM,   FUNC_TEXT, 16'h0001,   1'b1, CHK_RESULT, 1'b1, 16'd1}
    };

    function automatic void restart_text();
        foreach (txt_win[k]) txt_win[k] = '0;
        txt_pos  = 0;
        hit_seen = 1'b0;
    endfunction

    function automatic bit predict_match(input t_in_item it, output t_out_item res);
        int unsigned p;
        int unsigned first;
        bit          hit;
        res = '0;
        if (it.func == FUNC_LOAD) begin
            if (!load_open) begin
                pat_len   = 0;
                load_open = 1'b1;
                restart_text();
            end
            if (pat_len < PAT_MAX) begin
                pat_chars[pat_len] = it.char_value;
                pat_len++;
            end
            if (it.last)
                load_open = 1'b0;
            return 1'b0;
        end
        load_open = 1'b0;
        if (hit_seen) begin
            if (it.last)
                restart_text();
            return 1'b0;
        end
        for (int k = PAT_MAX - 1; k > 0; k--)
            txt_win[k] = txt_win[k-1];
        txt_win[0] = it.char_value;
        p = txt_pos;
        if (txt_pos < IDX_CAP)
            txt_pos++;
        hit   = 1'b0;
        first = 0;
        if (pat_len == 0) begin
            if (p + 1 >= 32'(cur_offset)) begin
                first = 32'(cur_offset);
                hit   = 1'b1;
            end
        end else if (p + 1 >= pat_len) begin
            first = p + 1 - pat_len;
            if (first >= 32'(cur_offset)) begin
                hit = 1'b1;
                for (int k = 0; k < pat_len; k++)
                    if (txt_win[k] != pat_chars[pat_len-1-k])
                        hit = 1'b0;
            end
        end
        if (hit && first > POS_LIMIT)
            hit = 1'b0;
        if (hit) begin
            res.found          = 1'b1;
            res.match_position = first[POS_FIELD_W-1:0];
            if (it.last)
                restart_text();
            else
                hit_seen = 1'b1;
            return 1'b1;
        end
        if (it.last) begin
            restart_text();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_in_item mk_item(input logic f, input logic [CHAR_FIELD_W-1:0] c,
                                         input logic l);
        t_in_item it;
        it.func       = f;
        it.char_value = c;
        it.last       = l;
        return it;
    endfunction

    function automatic logic [CHAR_FIELD_W-1:0] pick_char(input logic [CHAR_FIELD_W-1:0] a [3]);
        if ($urandom_range(0, 15) == 0)
            return CHAR_FIELD_W'($urandom);
        return a[$urandom_range(0, 2)];
    endfunction

    function automatic void flag_error(input string what);
        n_err++;
        if (n_err <= 10)
            $display("mismatch: %s", what);
    endfunction

    task automatic send_char(input t_in_item it, input t_check chk = CHK_MODEL,
                             input t_out_item typed = '0);
        t_out_item res;
        bit        got;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        got = predict_match(it, res);
        case (chk)
            CHK_MODEL:  if (got) result_q.push_back(res);
            CHK_RESULT: result_q.push_back(typed);
            default: ;
        endcase
        n_items++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_offset = v;
        n_cfg++;
    endtask

    // offset write, pattern load then several texts, some with the pattern planted and stray items mixed in
    task automatic random_phase();
        logic [CHAR_FIELD_W-1:0] alpha [3];
        logic [CHAR_FIELD_W-1:0] pat [$];
        logic [CHAR_FIELD_W-1:0] txt [$];
        int                      plen;
        int                      eff;
        int                      tlen;
        int                      at;
        bit                      open_end;
        case ($urandom_range(0, 9))
            0, 1:    write_offset('0);
            2:       write_offset('1);
            3:       write_offset(OFFSET_W'($urandom));
            default: write_offset(OFFSET_W'($urandom_range(1, 30)));
        endcase
        foreach (alpha[k]) alpha[k] = CHAR_FIELD_W'($urandom);
        case ($urandom_range(0, 7))
            0:       plen = $urandom_range(17, 20);
            1, 2:    plen = $urandom_range(7, 16);
            default: plen = $urandom_range(1, 6);
        endcase
        eff      = (plen > PAT_MAX) ? PAT_MAX : plen;
        open_end = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < plen; k++) begin
            pat.push_back(pick_char(alpha));
            send_char(mk_item(FUNC_LOAD, pat[k], !open_end && k == plen - 1));
        end
        repeat ($urandom_range(2, 6)) begin
            tlen = $urandom_range(1, 40);
            txt.delete();
            repeat (tlen) txt.push_back(pick_char(alpha));
            if ($urandom_range(0, 1) == 1 && tlen >= eff) begin
                at = $urandom_range(0, tlen - eff);
                for (int k = 0; k < eff; k++)
                    txt[at+k] = pat[k];
            end
            foreach (txt[k]) begin
                if ($urandom_range(0, 19) == 0)
                    send_char(mk_item(1'($urandom_range(0, 1)), CHAR_FIELD_W'($urandom),
                                      1'($urandom_range(0, 1))));
                send_char(mk_item(FUNC_TEXT, txt[k], k == tlen - 1));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_cnt > 0) begin
            stall_cnt   <= stall_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_cnt   <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (result_q.size() == 0) begin
                flag_error($sformatf("unexpected item found=%0b pos=%0d",
                                     o_out_item.found, o_out_item.match_position));
            end else begin
                want = result_q.pop_front();
                if (o_out_item.found !== want.found)
                    flag_error($sformatf("found expected %0b actual %0b",
                                         want.found, o_out_item.found));
                if (o_out_item.match_position !== want.match_position)
                    flag_error($sformatf("match_position expected %0d actual %0d",
                                         want.match_position, o_out_item.match_position));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_out_item typed;
        restart_text();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_OFFSET) begin
                write_offset(dir_rows[r].ch);
            end else begin
                typed.found          = dir_rows[r].found;
                typed.match_position = dir_rows[r].pos;
                send_char(mk_item(dir_rows[r].func, dir_rows[r].ch, dir_rows[r].last),
                          dir_rows[r].chk, typed);
            end
        end
        while (n_items < ITEM_TARGET) begin
            idle_on = ($urandom_range(0, 4) != 0);
            random_phase();
        end
        idle_on = 1'b0;
        repeat (2) random_phase();
        wait_idle();
        $display("run covered %0d items, %0d results and %0d offset writes,", n_items,
                 n_results, n_cfg);
        $display("with pattern reloads mid text, overlong patterns and random stalls");
        if (n_err == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
